// ===== rtl/acrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acrc_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_Z    = 8'h7A;
  localparam logic [6:0] RUN_LIMIT = 7'd74;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic REG_CODEC_MODE = 1'b0;
  localparam logic REG_MAX_RUN    = 1'b1;

  typedef struct packed {
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic expand_start;
    logic last_chunk;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/ascii_count_rle_codec_unit.sv =====
// Output: a result beat is registered from the input beat that causes it and appears in the cycle after it is taken.
// Throughput: encode takes one byte per cycle while the output is not stalled. A decode
// count byte of n copies is split into beats of up to four copies in the four-lane output
// register, one output beat per cycle while out_ready holds; input is held off until its last beat loads.
// Reset: synchronous rst selects encode, max_run 74, and clears all run state.
`timescale 1ns / 1ps
`default_nettype none
module ascii_count_rle_codec_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [6:0]  cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  data_byte,
  input  wire        end_of_buffer,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3,
  output logic [2:0] lanes_valid,
  output logic       bad_count,
  output logic       last_of_buffer
);

  acrc_pkg::cmd_t  cmd;
  acrc_pkg::stat_t stat;

  acrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acrc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_byte      (data_byte),
    .end_of_buffer  (end_of_buffer),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte0      (out_byte0),
    .out_byte1      (out_byte1),
    .out_byte2      (out_byte2),
    .out_byte3      (out_byte3),
    .lanes_valid    (lanes_valid),
    .bad_count      (bad_count),
    .last_of_buffer (last_of_buffer)
  );

endmodule
`default_nettype wire

// ===== rtl/acrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acrc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  acrc_pkg::stat_t   stat,
  output acrc_pkg::cmd_t    cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_EXPAND = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.emit   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = !stat.out_busy;
        cmd.take = in_valid && !stat.out_busy;
        if (cmd.take && stat.expand_start) begin
          state_next = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.emit = !stat.out_busy;
        if (cmd.emit && stat.last_chunk) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/acrc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acrc_dp (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire              cfg_index,
  input  wire [6:0]        cfg_data,
  input  wire [7:0]        data_byte,
  input  wire              end_of_buffer,
  input  acrc_pkg::cmd_t   cmd,
  output acrc_pkg::stat_t  stat,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [7:0]       out_byte0,
  output logic [7:0]       out_byte1,
  output logic [7:0]       out_byte2,
  output logic [7:0]       out_byte3,
  output logic [2:0]       lanes_valid,
  output logic             bad_count,
  output logic             last_of_buffer
);

  logic       codec_mode;
  logic [6:0] max_run;
  logic [7:0] held_symbol;
  logic [6:0] run_length;
  logic       expect_count_byte;
  logic [6:0] repeats_left;
  logic       eob_hold;

  logic [7:0] held_symbol_next;
  logic [6:0] run_length_next;
  logic       expect_count_byte_next;
  logic [6:0] repeats_left_next;
  logic       eob_hold_next;

  logic       res_valid;
  logic [2:0] res_n;
  logic [7:0] res_lane [4];
  logic       res_bad;
  logic       res_last;

  logic [6:0] lim;
  logic       flush;
  logic [6:0] run_base;
  logic [6:0] run_new;
  logic [7:0] held_new;
  logic [7:0] old_char;
  logic [7:0] new_char;
  logic       count_bad;
  logic [7:0] count_full;
  logic [6:0] count_val;
  logic [6:0] chunk_src;
  logic [2:0] chunk_n;
  logic       load;

  assign lim = (max_run == 7'd0) ? 7'd1 :
               (max_run > acrc_pkg::RUN_LIMIT) ? acrc_pkg::RUN_LIMIT : max_run;
  assign flush    = (run_length != 7'd0) &&
                    ((data_byte != held_symbol) || (run_length >= lim));
  assign run_base = flush ? 7'd0 : run_length;
  assign run_new  = (run_base == 7'd0) ? 7'd1 : run_base + 7'd1;
  assign held_new = (run_base == 7'd0) ? data_byte : held_symbol;
  assign old_char = {1'b0, run_length} + acrc_pkg::CHAR_ZERO;
  assign new_char = {1'b0, run_new} + acrc_pkg::CHAR_ZERO;

  assign count_bad  = (data_byte < acrc_pkg::CHAR_ZERO) || (data_byte > acrc_pkg::CHAR_Z);
  assign count_full = data_byte - acrc_pkg::CHAR_ZERO;
  assign count_val  = count_full[6:0];

  assign chunk_src = cmd.emit ? repeats_left : count_val;
  assign chunk_n   = (chunk_src > 7'd4) ? 3'd4 : chunk_src[2:0];

  always_comb begin
    held_symbol_next       = held_symbol;
    run_length_next        = run_length;
    expect_count_byte_next = expect_count_byte;
    repeats_left_next      = repeats_left;
    eob_hold_next          = eob_hold;
    res_valid              = 1'b0;
    res_n                  = 3'd0;
    res_bad                = 1'b0;
    res_last               = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res_lane[i] = 8'd0;
    end
    if (cmd.emit) begin
      res_valid         = 1'b1;
      res_n             = chunk_n;
      repeats_left_next = repeats_left - {4'd0, chunk_n};
      res_last          = eob_hold && (repeats_left <= 7'd4);
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < chunk_n) begin
          res_lane[i] = held_symbol;
        end
      end
    end else if (cmd.take) begin
      if (codec_mode == acrc_pkg::MODE_ENCODE) begin
        held_symbol_next = held_new;
        run_length_next  = end_of_buffer ? 7'd0 : run_new;
        res_last         = end_of_buffer;
        res_valid        = flush || end_of_buffer;
        if (flush) begin
          res_lane[0] = held_symbol;
          res_lane[1] = old_char;
          if (end_of_buffer) begin
            res_lane[2] = held_new;
            res_lane[3] = new_char;
            res_n       = 3'd4;
          end else begin
            res_n = 3'd2;
          end
        end else if (end_of_buffer) begin
          res_lane[0] = held_new;
          res_lane[1] = new_char;
          res_n       = 3'd2;
        end
      end else begin
        run_length_next = end_of_buffer ? 7'd0 : run_length;
        if (!expect_count_byte) begin
          held_symbol_next       = data_byte;
          expect_count_byte_next = !end_of_buffer;
          res_valid              = end_of_buffer;
          res_last               = 1'b1;
        end else begin
          expect_count_byte_next = 1'b0;
          if (count_bad) begin
            repeats_left_next = 7'd0;
            res_valid         = 1'b1;
            res_bad           = 1'b1;
            res_last          = end_of_buffer;
          end else if (count_val == 7'd0) begin
            repeats_left_next = 7'd0;
            res_valid         = end_of_buffer;
            res_last          = 1'b1;
          end else begin
            res_valid         = 1'b1;
            res_n             = chunk_n;
            repeats_left_next = count_val - {4'd0, chunk_n};
            eob_hold_next     = end_of_buffer;
            res_last          = end_of_buffer && (count_val <= 7'd4);
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < chunk_n) begin
                res_lane[i] = held_symbol;
              end
            end
          end
        end
      end
    end
  end

  assign load = res_valid;

  assign stat.out_busy     = out_valid && !out_ready;
  assign stat.expand_start = (codec_mode == acrc_pkg::MODE_DECODE) && expect_count_byte &&
                             !count_bad && (count_val > 7'd4);
  assign stat.last_chunk   = (repeats_left <= 7'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode        <= acrc_pkg::MODE_ENCODE;
      max_run           <= acrc_pkg::RUN_LIMIT;
      held_symbol       <= 8'd0;
      run_length        <= 7'd0;
      expect_count_byte <= 1'b0;
      repeats_left      <= 7'd0;
      eob_hold          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && (cfg_index == acrc_pkg::REG_CODEC_MODE)) begin
        codec_mode        <= cfg_data[0];
        held_symbol       <= 8'd0;
        run_length        <= 7'd0;
        expect_count_byte <= 1'b0;
        repeats_left      <= 7'd0;
      end else begin
        held_symbol       <= held_symbol_next;
        run_length        <= run_length_next;
        expect_count_byte <= expect_count_byte_next;
        repeats_left      <= repeats_left_next;
      end
      if (cfg_we && (cfg_index == acrc_pkg::REG_MAX_RUN)) begin
        max_run <= cfg_data;
      end
      eob_hold <= eob_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte0      <= res_lane[0];
      out_byte1      <= res_lane[1];
      out_byte2      <= res_lane[2];
      out_byte3      <= res_lane[3];
      lanes_valid    <= res_n;
      bad_count      <= res_bad;
      last_of_buffer <= res_last;
    end
  end

endmodule
`default_nettype wire
